@@ sv/adts_pkg.sv @@
// ----------------------------------------------------------------------------
// adts_pkg: shared types and constants for the ADTS deframer
// Phase codes, result status codes, tag signatures and result queue sizing.
// ----------------------------------------------------------------------------
package adts_pkg;

    typedef enum logic [2:0] {
        PH_HEAD    = 3'd0,
        PH_ID3     = 3'd1,
        PH_ADTS    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [2:0] ST_FRAME    = 3'd0;
    localparam logic [2:0] ST_END      = 3'd1;
    localparam logic [2:0] ST_BAD_TAG  = 3'd2;
    localparam logic [2:0] ST_BAD_ADTS = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_3 = 8'h33;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_G = 8'h47;

    localparam int HDR_DEPTH    = 10;
    localparam int ADTS_HDR_LEN = 7;
    localparam logic [28:0] ID3V1_REST = 29'd125;

    // result queue: one burst of a full ADTS header must always fit
    localparam int Q_DEPTH = 16;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_LIMIT = Q_DEPTH - ADTS_HDR_LEN;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
    } result_t;

endpackage

@@ sv/adts_deframer_with_tag_skip.sv @@
// ----------------------------------------------------------------------------
// adts_deframer_with_tag_skip: ADTS frame splitter with ID3 tag removal
// Cuts a byte stream into ADTS frames, dropping ID3v2 and ID3v1 tags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one stream byte per item, or an item
//   with end_flag set that closes the stream.
//   Output channel (out_valid/out_ready): frame bytes with last_of_frame on
//   the final byte, or one status item (clean end, bad tag, bad header,
//   truncated) after which the block halts and drops every further item.
//   Each item is decoded in the cycle it is accepted; its results go to a
//   16-entry result queue that feeds the output. Throughput is one input
//   item per cycle while in_ready is high. A completed ADTS header pushes
//   its seven bytes into the queue at once; in_ready stays high while the
//   queue has room for such a burst (at most 9 entries held), so the
//   input only waits when the receiver stalls and the queue fills up.
//   Reset (rst_n low) returns the block to a frame boundary, empties the
//   queue and clears the halt.
// ----------------------------------------------------------------------------
module adts_deframer_with_tag_skip (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_flag,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_frame,
    output logic [2:0] status
);
    import adts_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [3:0]    hcount_reg, hcount_next;
    logic [28:0]   skip_reg, skip_next;
    logic [12:0]   frame_reg, frame_next;
    logic          halted_reg, halted_next;
    logic [7:0]    hstore_reg [HDR_DEPTH];
    logic [7:0]    hs [HDR_DEPTH];
    logic          store_en;

    result_t       q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   qcnt_reg;
    logic [2:0]    push_n;
    result_t       push_e [ADTS_HDR_LEN];

    logic          in_fire, out_fire;
    logic [12:0]   fsize, fsize_rem;
    logic [12:0]   hsize;
    logic          adts_bad, id3_bad;
    logic [28:0]   id3_size;
    logic [28:0]   skip_dec;
    logic [12:0]   frame_dec;

    assign in_ready  = (qcnt_reg <= (Q_AW+1)'(Q_LIMIT));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (qcnt_reg != '0);
    assign out_fire  = out_valid && out_ready;

    assign out_byte      = q_reg[rd_ptr_reg].data;
    assign last_of_frame = q_reg[rd_ptr_reg].last;
    assign status        = q_reg[rd_ptr_reg].status;

    // header view with the incoming byte in its slot
    always_comb
    begin
        for (int k = 0; k < HDR_DEPTH; k++)
        begin
            hs[k] = (hcount_reg == 4'(k)) ? in_byte : hstore_reg[k];
        end
    end

    assign fsize     = {hs[3][1:0], hs[4], hs[5][7:5]};
    assign hsize     = hs[1][0] ? 13'd7 : 13'd9;
    assign fsize_rem = fsize - 13'd7;
    assign adts_bad  = (hs[0] != 8'hff) || ((hs[1] & 8'hf6) != 8'hf0) ||
                       (fsize < hsize) || (hs[2][5:2] > 4'd12);
    assign id3_bad   = (hs[3] < 8'd2) || (hs[3] > 8'd4) || (hs[4] == 8'hff) ||
                       hs[6][7] || hs[7][7] || hs[8][7] || hs[9][7];
    assign id3_size  = {1'b0, hs[6][6:0], hs[7][6:0], hs[8][6:0], hs[9][6:0]} +
                       (((hs[3] == 8'd4) && hs[5][4]) ? 29'd10 : 29'd0);
    assign skip_dec  = (skip_reg != '0) ? skip_reg - 29'd1 : skip_reg;
    assign frame_dec = (frame_reg != '0) ? frame_reg - 13'd1 : frame_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        skip_next   = skip_reg;
        frame_next  = frame_reg;
        halted_next = halted_reg;
        store_en    = 1'b0;
        push_n      = 3'd0;
        for (int k = 0; k < ADTS_HDR_LEN; k++)
        begin
            push_e[k] = '0;
        end
        if (in_fire && !halted_reg)
        begin
            if (end_flag)
            begin
                halted_next      = 1'b1;
                push_n           = 3'd1;
                push_e[0].status = (phase_reg == PH_HEAD && hcount_reg == '0) ?
                                   ST_END : ST_TRUNC;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                        begin
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        frame_next     = frame_dec;
                        push_n         = 3'd1;
                        push_e[0].data = in_byte;
                        push_e[0].last = (frame_dec == '0);
                        if (frame_dec == '0)
                        begin
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_HEAD:
                    begin
                        store_en    = 1'b1;
                        hcount_next = hcount_reg + 4'd1;
                        if (hcount_reg == 4'd2)
                        begin
                            if (hs[0] == CH_I && hs[1] == CH_D && hs[2] == CH_3)
                            begin
                                phase_next = PH_ID3;
                            end
                            else if (hs[0] == CH_T && hs[1] == CH_A && hs[2] == CH_G)
                            begin
                                hcount_next = '0;
                                skip_next   = ID3V1_REST;
                                phase_next  = PH_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_ADTS;
                            end
                        end
                    end
                    PH_ID3:
                    begin
                        store_en    = 1'b1;
                        hcount_next = hcount_reg + 4'd1;
                        if (hcount_reg == 4'(HDR_DEPTH - 1))
                        begin
                            if (id3_bad)
                            begin
                                halted_next      = 1'b1;
                                push_n           = 3'd1;
                                push_e[0].status = ST_BAD_TAG;
                            end
                            else
                            begin
                                hcount_next = '0;
                                skip_next   = id3_size;
                                phase_next  = (id3_size != '0) ? PH_SKIP : PH_HEAD;
                            end
                        end
                    end
                    PH_ADTS:
                    begin
                        store_en    = 1'b1;
                        hcount_next = hcount_reg + 4'd1;
                        if (hcount_reg == 4'(ADTS_HDR_LEN - 1))
                        begin
                            if (adts_bad)
                            begin
                                halted_next      = 1'b1;
                                push_n           = 3'd1;
                                push_e[0].status = ST_BAD_ADTS;
                            end
                            else
                            begin
                                hcount_next = '0;
                                frame_next  = fsize_rem;
                                push_n      = 3'(ADTS_HDR_LEN);
                                for (int k = 0; k < ADTS_HDR_LEN; k++)
                                begin
                                    push_e[k].data = hs[k];
                                end
                                push_e[ADTS_HDR_LEN-1].last = (fsize_rem == '0);
                                phase_next = (fsize_rem == '0) ? PH_HEAD : PH_PAYLOAD;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            hcount_reg <= '0;
            skip_reg   <= '0;
            frame_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            skip_reg   <= skip_next;
            frame_reg  <= frame_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en && hcount_reg < 4'(HDR_DEPTH))
        begin
            hstore_reg[hcount_reg] <= in_byte;
        end
    end

    // result queue, up to a full header burst written per cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            logic [Q_AW-1:0] offs;
            offs = Q_AW'(i) - wr_ptr_reg;
            if (offs < Q_AW'(push_n))
            begin
                q_reg[i] <= push_e[offs[2:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcnt_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + Q_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + Q_AW'(out_fire);
            qcnt_reg   <= qcnt_reg + (Q_AW+1)'(push_n) - (Q_AW+1)'(out_fire);
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("result queue overflow");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (push_n == 3'd0 && halted_next))
        else $error("result produced after halt");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_FRAME) |-> (!last_of_frame && out_byte == 8'h00))
        else $error("status item carries frame data");

    // a bad ID3v2 header halts with the count one past the last slot
    a_hcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        hcount_reg <= 4'(HDR_DEPTH))
        else $error("header count out of range");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (frame_reg != '0))
        else $error("payload phase with nothing left");

endmodule
